@@ hw/rtl/rcmp_pkg.sv @@
// Shared types, widths and register indexes for the RGBA color matrix pixel unit.
// Depends on nothing; every other file of the block imports it.
package rcmp_pkg;

   localparam int PIX_W                   = 8;
   localparam int COEF_W                  = 16;
   localparam int SRC_FRAC_W              = 16;
   localparam int QUO_W                   = PIX_W + SRC_FRAC_W;
   localparam int FRAC_W                  = SRC_FRAC_W + 1;
   localparam int LANES                   = 4;
   localparam int DIV_STAGES              = 4;
   localparam int CSR_INDEX_W             = 3;
   localparam int CSR_DATA_W              = LANES * COEF_W;
   localparam int COEFF_FRAC_BITS_DEFAULT = 12;

   localparam logic [PIX_W-1:0] ALPHA_FULL = 8'd255;

   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;
   localparam int LANE_ALPHA = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RED_ROW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_ROW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_ROW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_ROW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_OFFSETS = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] in_alpha;
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
   } req_pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_alpha;
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
   } rsp_pixel_type;

   typedef struct packed {
      logic [LANES-1:0][CSR_DATA_W-1:0] row;
      logic [CSR_DATA_W-1:0]            offsets;
   } coeff_set_type;

   typedef logic [LANES-1:0][QUO_W-1:0]  src_frac_type;
   typedef logic [LANES-1:0][FRAC_W-1:0] row_frac_type;

endpackage

@@ hw/rtl/rcmp_unpremul.sv @@
// Unpremultiply pipeline: three color lanes of restoring dividers spread over DIV_STAGES
// stages, and an alpha lane that divides by the constant 255 and rides along. Depends on rcmp_pkg.
module rcmp_unpremul import rcmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  req_pixel_type in_pixel,
   output logic          out_valid,
   output src_frac_type  out_frac
);

   localparam int STEPS = QUO_W / DIV_STAGES;

   typedef struct packed {
      logic [QUO_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic [PIX_W-1:0] rem;
      logic [PIX_W-1:0] den;
   } div_lane_type;

   typedef div_lane_type [LANES-1:0] div_word_type;

   function automatic div_lane_type div_steps(input div_lane_type cur);
      div_lane_type   nxt;
      logic [PIX_W:0] trial;
      nxt = cur;
      for (int i = 0; i < STEPS; i++) begin
         trial   = {nxt.rem, nxt.num[QUO_W-1]};
         nxt.num = {nxt.num[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, nxt.den}) begin
            nxt.rem = PIX_W'(trial - {1'b0, nxt.den});
            nxt.quo = {nxt.quo[QUO_W-2:0], 1'b1};
         end else begin
            nxt.rem = trial[PIX_W-1:0];
            nxt.quo = {nxt.quo[QUO_W-2:0], 1'b0};
         end
      end
      return nxt;
   endfunction

   div_word_type            word_ff  [DIV_STAGES];
   div_word_type            word_in  [DIV_STAGES];
   div_word_type            stage_src[DIV_STAGES];
   logic [DIV_STAGES-1:0]   valid_ff;
   logic [PIX_W-1:0]        color_den;

   always_comb begin
      color_den = (in_pixel.in_alpha == '0) ? ALPHA_FULL : in_pixel.in_alpha;
      stage_src[0][LANE_RED]   = '{num: {in_pixel.in_red, {SRC_FRAC_W{1'b0}}},
                                   quo: '0, rem: '0, den: color_den};
      stage_src[0][LANE_GREEN] = '{num: {in_pixel.in_green, {SRC_FRAC_W{1'b0}}},
                                   quo: '0, rem: '0, den: color_den};
      stage_src[0][LANE_BLUE]  = '{num: {in_pixel.in_blue, {SRC_FRAC_W{1'b0}}},
                                   quo: '0, rem: '0, den: color_den};
      // Alpha over 255 rounded up is alpha times 257, plus one for any nonzero alpha.
      stage_src[0][LANE_ALPHA] = '{num: '0,
                                   quo: QUO_W'({in_pixel.in_alpha, in_pixel.in_alpha})
                                      + QUO_W'(in_pixel.in_alpha != '0),
                                   rem: '0, den: ALPHA_FULL};
      for (int st = 1; st < DIV_STAGES; st++) begin
         stage_src[st] = word_ff[st-1];
      end
      for (int st = 0; st < DIV_STAGES; st++) begin
         for (int ln = 0; ln < LANE_ALPHA; ln++) begin
            word_in[st][ln] = div_steps(stage_src[st][ln]);
         end
         word_in[st][LANE_ALPHA] = stage_src[st][LANE_ALPHA];
      end
      // The last stage rounds the quotient up when a remainder is left.
      for (int ln = 0; ln < LANES; ln++) begin
         word_in[DIV_STAGES-1][ln].quo = word_in[DIV_STAGES-1][ln].quo
            + QUO_W'(word_in[DIV_STAGES-1][ln].rem != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int st = 0; st < DIV_STAGES; st++) begin
            word_ff[st] <= word_in[st];
         end
      end
   end

   always_comb begin
      out_valid = valid_ff[DIV_STAGES-1];
      for (int ln = 0; ln < LANES; ln++) begin
         out_frac[ln] = word_ff[DIV_STAGES-1][ln].quo;
      end
   end

endmodule

@@ hw/rtl/rcmp_matrix.sv @@
// Color matrix pipeline: products, two partial sums, one with offset, final sum, clamp.
// Depends on rcmp_pkg.
module rcmp_matrix import rcmp_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  src_frac_type  in_frac,
   input  coeff_set_type coeff,
   output logic          out_valid,
   output row_frac_type  out_frac
);

   localparam int PROD_W = COEF_W + QUO_W + 1;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] ROW_TOP =
      {{(ACC_W-1){1'b0}}, 1'b1} <<< (COEFF_FRAC_BITS + SRC_FRAC_W);

   logic signed [PROD_W-1:0] prod_in [LANES][LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES][LANES];
   logic signed [ACC_W-1:0]  pair_a_in [LANES];
   logic signed [ACC_W-1:0]  pair_a_ff [LANES];
   logic signed [ACC_W-1:0]  pair_b_in [LANES];
   logic signed [ACC_W-1:0]  pair_b_ff [LANES];
   row_frac_type             row_in;
   row_frac_type             row_ff;
   logic [2:0]               valid_ff;

   always_comb begin
      logic signed [COEF_W-1:0] coef;
      logic signed [QUO_W:0]    src;
      for (int r = 0; r < LANES; r++) begin
         for (int k = 0; k < LANES; k++) begin
            coef = $signed(coeff.row[r][COEF_W*k +: COEF_W]);
            src  = $signed({1'b0, in_frac[k]});
            prod_in[r][k] = PROD_W'(coef) * PROD_W'(src);
         end
      end
   end

   always_comb begin
      logic signed [COEF_W-1:0] offset;
      for (int r = 0; r < LANES; r++) begin
         offset       = $signed(coeff.offsets[COEF_W*r +: COEF_W]);
         pair_a_in[r] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]);
         pair_b_in[r] = ACC_W'(prod_ff[r][2]) + ACC_W'(prod_ff[r][3])
                      + (ACC_W'(offset) <<< SRC_FRAC_W);
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] sum;
      logic [ACC_W-1:0]        clip;
      for (int r = 0; r < LANES; r++) begin
         sum = pair_a_ff[r] + pair_b_ff[r];
         if (sum < 0) begin
            clip = '0;
         end else if (sum > ROW_TOP) begin
            clip = ROW_TOP;
         end else begin
            clip = sum;
         end
         row_in[r] = FRAC_W'(clip >> COEFF_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         pair_a_ff <= pair_a_in;
         pair_b_ff <= pair_b_in;
         row_ff    <= row_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_frac  = row_ff;

endmodule

@@ hw/rtl/rcmp_premul.sv @@
// Premultiply and scale to 8 bits: color times alpha, then times 255; holds the output word.
// Depends on rcmp_pkg.
module rcmp_premul import rcmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  row_frac_type  in_frac,
   output logic          out_valid,
   output rsp_pixel_type out_pixel
);

   localparam int CA_W = 2 * FRAC_W;
   localparam int CS_W = CA_W + PIX_W;
   localparam int AS_W = FRAC_W + PIX_W;

   logic [CA_W-1:0]  ca_in [3];
   logic [CA_W-1:0]  ca_ff [3];
   logic [PIX_W-1:0] alpha_in;
   logic [PIX_W-1:0] alpha_ff;
   rsp_pixel_type    pixel_in;
   rsp_pixel_type    pixel_ff;
   logic [1:0]       valid_ff;

   always_comb begin
      logic [AS_W-1:0] alpha_scaled;
      for (int c = 0; c < 3; c++) begin
         ca_in[c] = CA_W'(in_frac[c]) * CA_W'(in_frac[LANE_ALPHA]);
      end
      alpha_scaled = AS_W'(in_frac[LANE_ALPHA]) * AS_W'(ALPHA_FULL);
      alpha_in     = alpha_scaled[SRC_FRAC_W +: PIX_W];
   end

   always_comb begin
      logic [CS_W-1:0] scaled [3];
      for (int c = 0; c < 3; c++) begin
         scaled[c] = CS_W'(ca_ff[c]) * CS_W'(ALPHA_FULL);
      end
      pixel_in.out_alpha = alpha_ff;
      pixel_in.out_red   = scaled[LANE_RED][2*SRC_FRAC_W +: PIX_W];
      pixel_in.out_green = scaled[LANE_GREEN][2*SRC_FRAC_W +: PIX_W];
      pixel_in.out_blue  = scaled[LANE_BLUE][2*SRC_FRAC_W +: PIX_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ca_ff    <= ca_in;
         alpha_ff <= alpha_in;
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_pixel = pixel_ff;

endmodule

@@ hw/rtl/rgba_color_matrix_pixel_unit.sv @@
// Top level of the RGBA color matrix pixel unit: configuration registers and the pipeline.
// Depends on rcmp_pkg, rcmp_unpremul, rcmp_matrix and rcmp_premul.
//
// The unit takes one premultiplied ARGB word per clock and returns one word per clock
// while no result is stalled. A word passes nine register stages on its way to rsp_data:
// four stages of the unpremultiply divider (six quotient bits per stage), three
// stages of the color matrix and two stages of the premultiply.
// When a result waits and rsp_stall is high, the whole pipeline holds and req_stall rises.
// The five matrix registers are always ready and should be written only while the pipeline
// holds no word.
module rgba_color_matrix_pixel_unit import rcmp_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_pixel_type          req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_pixel_type          rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEFF_FRAC_BITS;

   coeff_set_type coeff_ff;
   coeff_set_type coeff_in;
   logic          advance;
   logic          unpremul_valid;
   src_frac_type  unpremul_frac;
   logic          matrix_valid;
   row_frac_type  matrix_frac;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      coeff_in = coeff_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RED_ROW:     coeff_in.row[LANE_RED]   = csr_data;
            CSR_GREEN_ROW:   coeff_in.row[LANE_GREEN] = csr_data;
            CSR_BLUE_ROW:    coeff_in.row[LANE_BLUE]  = csr_data;
            CSR_ALPHA_ROW:   coeff_in.row[LANE_ALPHA] = csr_data;
            CSR_ROW_OFFSETS: coeff_in.offsets         = csr_data;
            default:         coeff_in = coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < LANES; r++) begin
            coeff_ff.row[r] <= CSR_DATA_W'(COEF_ONE) << (COEF_W * r);
         end
         coeff_ff.offsets <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   rcmp_unpremul u_unpremul (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_pixel  (req_data),
      .out_valid (unpremul_valid),
      .out_frac  (unpremul_frac)
   );

   rcmp_matrix #(
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (unpremul_valid),
      .in_frac   (unpremul_frac),
      .coeff     (coeff_ff),
      .out_valid (matrix_valid),
      .out_frac  (matrix_frac)
   );

   rcmp_premul u_premul (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (matrix_valid),
      .in_frac   (matrix_frac),
      .out_valid (rsp_valid),
      .out_pixel (rsp_data)
   );

endmodule

@@ hw/rtl/rcmp_checker.sv @@
// Port-level assertions for the RGBA color matrix pixel unit, bound to its top level.
// Depends on rcmp_pkg and rgba_color_matrix_pixel_unit.
module rcmp_checker import rcmp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_pixel_type          rsp_data
);

   // A stalled result word stays in place.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // The input side is held back only while a result word waits.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   // Premultiplied colors never exceed the result alpha.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_red <= rsp_data.out_alpha
                 && rsp_data.out_green <= rsp_data.out_alpha
                 && rsp_data.out_blue <= rsp_data.out_alpha)
      else $error("result color above result alpha");

   // Reset empties the pipeline.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

bind rgba_color_matrix_pixel_unit rcmp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
